/* sv/mep_pkg.sv */
// Shared types, constants and colour tables for the Mandelbrot escape-time pixel unit.
`timescale 1ns / 1ps

package mep_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 12;
  localparam int MAX_ITER  = 256;

  localparam int ITER_W    = $clog2(MAX_ITER + 1);
  localparam int LUT_IDX_W = $clog2(MAX_ITER);
  localparam int COUNT_W   = 9;
  localparam int CFG_W     = 13;
  localparam int ADDR_W    = 26;

  // Q4.F coordinate and z width, and the width of a full square or product
  localparam int Q_W  = FRAC_BITS + 4;
  localparam int SQ_W = 2 * Q_W;

  // Dividend for the coordinate divider: col*3 followed by F zero bits
  localparam int NUM_W     = COORD_W + 2;
  localparam int DIVD_W    = NUM_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // Register indexes of the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // 2.25 and 1.5 in Q4.F, and 4.0 at 2F fraction bits
  localparam logic [Q_W-1:0]  COL_OFFSET = Q_W'(64'd9 << (FRAC_BITS - 2));
  localparam logic [Q_W-1:0]  ROW_OFFSET = Q_W'(64'd3 << (FRAC_BITS - 1));
  localparam logic [SQ_W-1:0] ESCAPE_LIMIT = SQ_W'(128'd1 << (2 * FRAC_BITS + 2));

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

  typedef struct packed {
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
    logic               inside_set;
    logic [7:0]         red_byte;
    logic [7:0]         green_byte;
    logic [7:0]         blue_byte;
    logic [ADDR_W-1:0]  pixel_address;
  } rsp_t;

  typedef logic [MAX_ITER-1:0][7:0] curve_lut_t;

  // Largest k <= 255 with (k/255)^den <= (i/MAX_ITER)^num, for every count i
  function automatic curve_lut_t build_curve(int num, int den);
    curve_lut_t   lut;
    logic [127:0] rhs;
    logic [127:0] mpow;
    logic [127:0] lhs;
    logic [7:0]   k;
    logic [7:0]   c;
    for (int i = 0; i < MAX_ITER; i++) begin
      rhs  = 128'd1;
      mpow = 128'd1;
      for (int e = 0; e < den; e++) rhs = rhs * 128'd255;
      for (int e = 0; e < num; e++) rhs = rhs * 128'(i);
      for (int e = 0; e < num; e++) mpow = mpow * 128'(MAX_ITER);
      k = 8'd0;
      for (int b = 7; b >= 0; b--) begin
        c   = k | (8'd1 << b);
        lhs = mpow;
        for (int e = 0; e < den; e++) lhs = lhs * 128'(c);
        if (!(rhs < lhs)) k = c;
      end
      lut[i] = k;
    end
    return lut;
  endfunction

  localparam curve_lut_t RED_LUT   = build_curve(3, 5);
  localparam curve_lut_t GREEN_LUT = build_curve(1, 2);
  localparam curve_lut_t BLUE_LUT  = build_curve(2, 5);

endpackage

/* sv/mandelbrot_escape_pixel_unit.sv */
// Mandelbrot escape-time pixel unit: coordinate divider, square-add loop and colour lookup.
//
// One request (pixel column and row) is taken while the unit is idle. Each request runs a
// single 42-step restoring divider, once for the real and once for the imaginary coordinate,
// and then the complex square-add loop, which per iteration passes through S_MUL, with its
// three 32x32 multipliers, and S_UPD, with the escape test and saturating update. A point
// inside the set ends after MAX_ITER updates (the last pass skips the escape test). Results
// sit in an output register, so a new request is taken while the previous result still
// waits; the unit is ready for it as soon as the result is loaded into that register.
// The user must write image_width and image_height only while idle; the block itself does
// not enforce it. A value of zero acts as one.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  mep_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output mep_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mep_pkg::CFG_W-1:0]   cfg_data
);

  localparam int SUM_W = mep_pkg::SQ_W - mep_pkg::FRAC_BITS + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_COL = 3'd1;
  localparam logic [2:0] S_DIV_ROW = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_UPD     = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0]                          state;
  logic [mep_pkg::CFG_W-1:0]           image_width;
  logic [mep_pkg::CFG_W-1:0]           image_height;
  logic [mep_pkg::CFG_W-1:0]           width_eff;
  logic [mep_pkg::CFG_W-1:0]           height_eff;

  logic [mep_pkg::NUM_W-1:0]           row_num;
  logic [mep_pkg::CFG_W-1:0]           divisor;
  logic [mep_pkg::CFG_W-1:0]           rem;
  logic [mep_pkg::DIVD_W-1:0]          quo;
  logic [mep_pkg::DIV_CNT_W-1:0]       div_cnt;
  logic [mep_pkg::ADDR_W-1:0]          addr;

  logic signed [mep_pkg::Q_W-1:0]      cr;
  logic signed [mep_pkg::Q_W-1:0]      ci;
  logic signed [mep_pkg::Q_W-1:0]      zr;
  logic signed [mep_pkg::Q_W-1:0]      zi;
  logic [mep_pkg::SQ_W-1:0]            sq_r;
  logic [mep_pkg::SQ_W-1:0]            sq_i;
  logic signed [mep_pkg::SQ_W-1:0]     prod_ri;
  logic [mep_pkg::ITER_W-1:0]          iter;

  // divider step
  logic [mep_pkg::CFG_W:0]             rem_sh;
  logic                                take;
  logic [mep_pkg::CFG_W-1:0]           rem_step;
  logic [mep_pkg::DIVD_W-1:0]          quo_step;
  logic                                div_last;
  logic [mep_pkg::Q_W-1:0]             coord_off;
  logic signed [mep_pkg::Q_W-1:0]      coord_val;

  // request decode
  logic [mep_pkg::NUM_W-1:0]           col_num_in;
  logic [mep_pkg::NUM_W-1:0]           row_num_in;
  logic [mep_pkg::ADDR_W-3:0]          pix_index;

  // square-add update
  logic [mep_pkg::SQ_W-1:0]            mag_sum;
  logic                                escape;
  logic signed [mep_pkg::SQ_W:0]       diff_sq;
  logic signed [SUM_W-2:0]             re_sh;
  logic signed [SUM_W-2:0]             im_sh;
  logic signed [SUM_W-1:0]             re_sum;
  logic signed [SUM_W-1:0]             im_sum;

  logic                                in_set;
  logic [mep_pkg::LUT_IDX_W-1:0]       lut_idx;
  logic                                rsp_load;

  function automatic logic [mep_pkg::Q_W-1:0] to_coord(
    input logic [mep_pkg::DIVD_W-1:0] q,
    input logic [mep_pkg::Q_W-1:0]    off
  );
    logic [mep_pkg::Q_W:0] diff;
    diff = {1'b0, q[mep_pkg::Q_W-1:0]} - {1'b0, off};
    // integer part of 16 or more, or a positive result past the top of Q4.F
    if (|q[mep_pkg::DIVD_W-1:mep_pkg::Q_W]) return mep_pkg::Q_MAX;
    else if (diff[mep_pkg::Q_W]) return diff[mep_pkg::Q_W-1:0];
    else if (diff[mep_pkg::Q_W-1]) return mep_pkg::Q_MAX;
    else return diff[mep_pkg::Q_W-1:0];
  endfunction

  function automatic logic [mep_pkg::Q_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-mep_pkg::Q_W:0] top;
    top = v[SUM_W-1:mep_pkg::Q_W-1];
    if ((&top) || !(|top)) return v[mep_pkg::Q_W-1:0];
    else if (v[SUM_W-1]) return mep_pkg::Q_MIN;
    else return mep_pkg::Q_MAX;
  endfunction

  assign width_eff  = (image_width == '0) ? mep_pkg::CFG_W'(1) : image_width;
  assign height_eff = (image_height == '0) ? mep_pkg::CFG_W'(1) : image_height;

  assign req_ready = (state == S_IDLE);

  assign col_num_in = mep_pkg::NUM_W'({req.pixel_col, 1'b0}) + mep_pkg::NUM_W'(req.pixel_col);
  assign row_num_in = mep_pkg::NUM_W'({req.pixel_row, 1'b0}) + mep_pkg::NUM_W'(req.pixel_row);
  assign pix_index  = (mep_pkg::ADDR_W - 2)'(req.pixel_row) * (mep_pkg::ADDR_W - 2)'(width_eff)
                    + (mep_pkg::ADDR_W - 2)'(req.pixel_col);

  assign rem_sh    = {rem, quo[mep_pkg::DIVD_W-1]};
  assign take      = rem_sh >= {1'b0, divisor};
  assign rem_step  = take ? mep_pkg::CFG_W'(rem_sh - {1'b0, divisor})
                          : rem_sh[mep_pkg::CFG_W-1:0];
  assign quo_step  = {quo[mep_pkg::DIVD_W-2:0], take};
  assign div_last  = (div_cnt == mep_pkg::DIV_CNT_W'(mep_pkg::DIVD_W - 1));
  assign coord_off = (state == S_DIV_COL) ? mep_pkg::COL_OFFSET : mep_pkg::ROW_OFFSET;
  assign coord_val = to_coord(quo_step, coord_off);

  assign mag_sum = sq_r + sq_i;
  assign escape  = mag_sum >= mep_pkg::ESCAPE_LIMIT;
  assign diff_sq = $signed({1'b0, sq_r}) - $signed({1'b0, sq_i});
  assign re_sh   = diff_sq[mep_pkg::SQ_W:mep_pkg::FRAC_BITS];
  assign im_sh   = $signed(prod_ri[mep_pkg::SQ_W-1:mep_pkg::FRAC_BITS-1]);
  assign re_sum  = SUM_W'(re_sh) + SUM_W'(cr);
  assign im_sum  = SUM_W'(im_sh) + SUM_W'(ci);

  assign in_set   = (iter == mep_pkg::ITER_W'(mep_pkg::MAX_ITER));
  assign lut_idx  = iter[mep_pkg::LUT_IDX_W-1:0];
  assign rsp_load = (state == S_FIN) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      image_width  <= mep_pkg::WIDTH_RESET;
      image_height <= mep_pkg::HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mep_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          mep_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken; a new one may replace it in the same cycle
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            quo     <= {col_num_in, mep_pkg::FRAC_BITS'(0)};
            row_num <= row_num_in;
            divisor <= width_eff;
            rem     <= '0;
            div_cnt <= '0;
            addr    <= {pix_index, 2'b00};
            state   <= S_DIV_COL;
          end
        end
        S_DIV_COL: begin
          if (div_last) begin
            cr      <= coord_val;
            quo     <= {row_num, mep_pkg::FRAC_BITS'(0)};
            divisor <= height_eff;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV_ROW;
          end else begin
            rem     <= rem_step;
            quo     <= quo_step;
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_DIV_ROW: begin
          if (div_last) begin
            ci    <= coord_val;
            zr    <= '0;
            zi    <= '0;
            iter  <= '0;
            state <= S_MUL;
          end else begin
            rem     <= rem_step;
            quo     <= quo_step;
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_MUL: begin
          sq_r    <= mep_pkg::SQ_W'(zr * zr);
          sq_i    <= mep_pkg::SQ_W'(zi * zi);
          prod_ri <= mep_pkg::SQ_W'(zr * zi);
          state   <= S_UPD;
        end
        S_UPD: begin
          if (escape) begin
            state <= S_FIN;
          end else begin
            zr   <= saturate(re_sum);
            zi   <= saturate(im_sum);
            iter <= iter + 1'b1;
            if (iter == mep_pkg::ITER_W'(mep_pkg::MAX_ITER - 1)) state <= S_FIN;
            else state <= S_MUL;
          end
        end
        S_FIN: begin
          // hold here while the previous result is still waiting
          if (rsp_load) begin
            rsp.escape_count  <= mep_pkg::COUNT_W'(iter);
            rsp.inside_set    <= in_set;
            rsp.red_byte      <= in_set ? 8'd0 : mep_pkg::RED_LUT[lut_idx];
            rsp.green_byte    <= in_set ? 8'd0 : mep_pkg::GREEN_LUT[lut_idx];
            rsp.blue_byte     <= in_set ? 8'd0 : mep_pkg::BLUE_LUT[lut_idx];
            rsp.pixel_address <= addr;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a pixel was in progress");

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.inside_set |->
      (rsp.red_byte == 8'd0 && rsp.green_byte == 8'd0 && rsp.blue_byte == 8'd0))
    else $error("inside point with nonzero colour");

  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (rsp.inside_set == (rsp.escape_count == mep_pkg::COUNT_W'(mep_pkg::MAX_ITER))))
    else $error("inside flag disagrees with escape count");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_UPD) |-> iter <= mep_pkg::ITER_W'(mep_pkg::MAX_ITER))
    else $error("iteration count ran past the limit");

endmodule
